// ===== rtl/binary_max_heap_queue_unit_assert.svh =====
// Assertion macros shared by the heap queue RTL.
`ifndef BINARY_MAX_HEAP_QUEUE_UNIT_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BMHQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bmhq_pkg.sv =====
// Package: types and constants for the heap queue.
package bmhq_pkg;

   localparam int DEPTH_DEF     = 256;
   localparam int KEY_WIDTH_DEF = 32;
   localparam int MAX_KEY_W     = 32;
   localparam int COUNT_W       = 8;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } bmhq_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP,
      S_TOP,
      S_LAST,
      S_DN_L,
      S_DN_R,
      S_WR,
      S_RESP
   } bmhq_state_type;

   typedef struct packed {
      logic                  valid;
      logic [MAX_KEY_W-1:0]  max_key;
      bmhq_status_type       status;
      logic [COUNT_W-1:0]    entry_count;
   } bmhq_rsp_type;

endpackage

// ===== rtl/bmhq_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bmhq_ctrl.sv =====
// Heap sequencer: sift-up on insert, sift-down on remove, one memory access pair a cycle.
`include "binary_max_heap_queue_unit_assert.svh"

module bmhq_ctrl #(
   parameter int DEPTH     = bmhq_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic signed [31:0]            req_new_key,
   output bmhq_pkg::bmhq_rsp_type        res,
   input  logic                          res_take,
   output logic                          mem_we,
   output logic [$clog2(DEPTH)-1:0]      mem_waddr,
   output logic [KEY_WIDTH-1:0]          mem_wdata,
   output logic                          mem_re,
   output logic [$clog2(DEPTH)-1:0]      mem_raddr,
   input  logic [KEY_WIDTH-1:0]          mem_rdata
);

   localparam int IDX_W     = $clog2(DEPTH);
   localparam int KID_W     = IDX_W + 1;
   localparam int COUNT_W   = bmhq_pkg::COUNT_W;
   localparam int MAX_KEY_W = bmhq_pkg::MAX_KEY_W;
   localparam logic [IDX_W-1:0] CAP      = IDX_W'(DEPTH - 1);
   localparam logic [IDX_W-1:0] ROOT     = IDX_W'(1);
   localparam logic [KID_W-1:0] KID_ROOT = KID_W'(2);

   bmhq_pkg::bmhq_state_type  state_ff, state_in;
   bmhq_pkg::bmhq_status_type status_ff, status_in;
   logic [IDX_W-1:0]          cnt_ff, cnt_in;
   logic [IDX_W-1:0]          pos_ff, pos_in;
   logic [KID_W-1:0]          kid_ff, kid_in;
   logic signed [KEY_WIDTH-1:0] val_ff, val_in;
   logic signed [KEY_WIDTH-1:0] left_ff, left_in;
   logic signed [KEY_WIDTH-1:0] top_ff, top_in;

   logic signed [KEY_WIDTH-1:0] rd_key;
   logic signed [KEY_WIDTH-1:0] key_in;
   logic [63:0]                 key_raw;
   logic signed [63:0]          top_wide;

   assign rd_key   = mem_rdata;
   assign key_raw  = 64'($unsigned(req_new_key));
   assign key_in   = key_raw[KEY_WIDTH-1:0];
   assign top_wide = 64'(top_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmhq_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      status_ff <= status_in;
      pos_ff    <= pos_in;
      kid_ff    <= kid_in;
      val_ff    <= val_in;
      left_ff   <= left_in;
      top_ff    <= top_in;
   end

   always_comb begin
      logic signed [KEY_WIDTH-1:0] child_key;
      logic [KID_W-1:0]            child_idx;
      logic [KID_W-1:0]            next_kid;
      logic [IDX_W-1:0]            up_pos;
      logic                        eval;

      state_in  = state_ff;
      status_in = status_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      kid_in    = kid_ff;
      val_in    = val_ff;
      left_in   = left_ff;
      top_in    = top_ff;
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = val_ff;
      mem_re    = 1'b0;
      mem_raddr = ROOT;
      req_ready = (state_ff == bmhq_pkg::S_IDLE);
      child_key = left_ff;
      child_idx = kid_ff;
      next_kid  = '0;
      up_pos    = pos_ff >> 1;
      eval      = 1'b0;

      case (state_ff)
         bmhq_pkg::S_IDLE: begin
            if (req_valid) begin
               status_in = bmhq_pkg::ST_DONE;
               top_in    = '0;
               if (req_type == bmhq_pkg::REQ_INSERT) begin
                  if (cnt_ff == CAP) begin
                     status_in = bmhq_pkg::ST_FULL;
                     state_in  = bmhq_pkg::S_RESP;
                  end else begin
                     cnt_in = cnt_ff + IDX_W'(1);
                     pos_in = cnt_ff + IDX_W'(1);
                     val_in = key_in;
                     if (cnt_ff == '0) begin
                        state_in = bmhq_pkg::S_WR;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = (cnt_ff + IDX_W'(1)) >> 1;
                        state_in  = bmhq_pkg::S_UP;
                     end
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = bmhq_pkg::ST_EMPTY;
                     state_in  = bmhq_pkg::S_RESP;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = ROOT;
                     state_in  = bmhq_pkg::S_TOP;
                  end
               end
            end
         end
         bmhq_pkg::S_UP: begin
            // rd_key is the parent of pos_ff
            if (val_ff > rd_key) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff;
               mem_wdata = rd_key;
               pos_in    = up_pos;
               if (up_pos == ROOT) begin
                  state_in = bmhq_pkg::S_WR;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = up_pos >> 1;
               end
            end else begin
               state_in = bmhq_pkg::S_WR;
            end
         end
         bmhq_pkg::S_TOP: begin
            top_in    = rd_key;
            mem_re    = 1'b1;
            mem_raddr = cnt_ff;
            state_in  = bmhq_pkg::S_LAST;
         end
         bmhq_pkg::S_LAST: begin
            val_in = rd_key;
            cnt_in = cnt_ff - IDX_W'(1);
            pos_in = ROOT;
            kid_in = KID_ROOT;
            if (KID_ROOT <= KID_W'(cnt_ff - IDX_W'(1))) begin
               mem_re    = 1'b1;
               mem_raddr = KID_ROOT[IDX_W-1:0];
               state_in  = bmhq_pkg::S_DN_L;
            end else begin
               state_in = bmhq_pkg::S_WR;
            end
         end
         bmhq_pkg::S_DN_L: begin
            left_in = rd_key;
            if (kid_ff < KID_W'(cnt_ff)) begin
               mem_re    = 1'b1;
               mem_raddr = kid_ff[IDX_W-1:0] + IDX_W'(1);
               state_in  = bmhq_pkg::S_DN_R;
            end else begin
               child_key = rd_key;
               child_idx = kid_ff;
               eval      = 1'b1;
            end
         end
         bmhq_pkg::S_DN_R: begin
            // left wins ties
            if (rd_key > left_ff) begin
               child_key = rd_key;
               child_idx = kid_ff + KID_W'(1);
            end
            eval = 1'b1;
         end
         bmhq_pkg::S_WR: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = val_ff;
            state_in  = bmhq_pkg::S_RESP;
         end
         bmhq_pkg::S_RESP: begin
            if (res_take) begin
               state_in = bmhq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bmhq_pkg::S_IDLE;
         end
      endcase

      if (eval) begin
         next_kid = child_idx << 1;
         if (child_key > val_ff) begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = child_key;
            pos_in    = child_idx[IDX_W-1:0];
            kid_in    = next_kid;
            if (next_kid <= KID_W'(cnt_ff)) begin
               mem_re    = 1'b1;
               mem_raddr = next_kid[IDX_W-1:0];
               state_in  = bmhq_pkg::S_DN_L;
            end else begin
               state_in = bmhq_pkg::S_WR;
            end
         end else begin
            state_in = bmhq_pkg::S_WR;
         end
      end
   end

   assign res.valid       = (state_ff == bmhq_pkg::S_RESP);
   assign res.max_key     = top_wide[MAX_KEY_W-1:0];
   assign res.status      = status_ff;
   assign res.entry_count = COUNT_W'(cnt_ff);

   `BMHQ_ASSERT_NOW(a_rw_distinct, clock, reset, mem_we && mem_re, mem_waddr != mem_raddr,
      "heap read and write hit the same entry")
   `BMHQ_ASSERT_NOW(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CAP,
      "fill count above capacity")

endmodule

// ===== rtl/binary_max_heap_queue_unit.sv =====
// Binary max-heap priority queue: one insert or remove-max per request item.
// Insert: r = parent reads in sift-up (r <= log2 DEPTH), then the key is written.
// Remove: top and last reads, then c = sift-down child reads, two per level with both children
// through the single RAM read port (c <= 2 log2 DEPTH). Rejects (full or empty) skip the heap.
// One item in flight; the next item is accepted the cycle after its result is registered.
// Synchronous active-high reset empties the queue; heap RAM contents are not cleared.
`include "binary_max_heap_queue_unit_assert.svh"

module binary_max_heap_queue_unit #(
   parameter int DEPTH     = bmhq_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic signed [31:0]                req_new_key,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [bmhq_pkg::MAX_KEY_W-1:0] rsp_max_key,
   output logic [1:0]                        rsp_status,
   output logic [bmhq_pkg::COUNT_W-1:0]      rsp_entry_count
);

   localparam int IDX_W = $clog2(DEPTH);

   bmhq_pkg::bmhq_rsp_type res;
   logic                   res_take;
   logic                   mem_we, mem_re;
   logic [IDX_W-1:0]       mem_waddr, mem_raddr;
   logic [KEY_WIDTH-1:0]   mem_wdata, mem_rdata;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bmhq_pkg::MAX_KEY_W-1:0]    rsp_key_ff;
   logic [1:0]                        rsp_status_ff;
   logic [bmhq_pkg::COUNT_W-1:0]      rsp_count_ff;

   bmhq_ctrl #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_new_key (req_new_key),
      .res         (res),
      .res_take    (res_take),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re      (mem_re),
      .mem_raddr   (mem_raddr),
      .mem_rdata   (mem_rdata)
   );

   bmhq_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // output register: free when empty or being drained
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.valid && res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res.valid && res_take) begin
         rsp_key_ff    <= res.max_key;
         rsp_status_ff <= res.status;
         rsp_count_ff  <= res.entry_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_key     = rsp_key_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   `BMHQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready,
      "request accepted but sequencer still idle")
   `BMHQ_ASSERT_NOW(a_reject_zero_key, clock, reset,
      rsp_valid && (rsp_status != bmhq_pkg::ST_DONE), rsp_max_key == '0,
      "rejected item carries a nonzero key")

endmodule

// ===== bench/binary_max_heap_queue_unit_tb.sv =====
// Testbench for the heap priority queue: random and directed traffic checked against a heap model.
`timescale 1ns / 100ps

module binary_max_heap_queue_unit_tb;

   localparam int DEPTH_DEF   = bmhq_pkg::DEPTH_DEF;
   localparam int MAX_KEY_W   = bmhq_pkg::MAX_KEY_W;
   localparam int COUNT_W     = bmhq_pkg::COUNT_W;
   localparam int CAPACITY    = DEPTH_DEF - 1;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic signed [MAX_KEY_W-1:0] max_key;
      bmhq_pkg::bmhq_status_type   status;
      logic [COUNT_W-1:0]          entry_count;
   } queue_result_type;

   // Mirrors the heap and keeps the results still owed by the block.
   class heap_queue_scoreboard;
      logic signed [31:0] slot [0:DEPTH_DEF-1];
      int unsigned        fill_level;
      queue_result_type   pending [$];
      int inserts, removes, full_refusals, empty_refusals, peak_fill, compared, mismatches;

      function void note_request(logic kind, logic signed [31:0] key);
         queue_result_type   r;
         int unsigned        pos, hole, kid;
         logic signed [31:0] moving;
         bit                 settled;
         r.max_key = '0;
         r.status  = bmhq_pkg::ST_DONE;
         if (kind == bmhq_pkg::REQ_INSERT) begin
            inserts++;
            if (fill_level >= CAPACITY) begin
               r.status = bmhq_pkg::ST_FULL;
               full_refusals++;
            end else begin
               fill_level++;
               pos = fill_level;
               // rise while the parent is strictly smaller
               while (pos != 1 && key > slot[pos / 2]) begin
                  slot[pos] = slot[pos / 2];
                  pos = pos / 2;
               end
               slot[pos] = key;
            end
         end else begin
            removes++;
            if (fill_level == 0) begin
               r.status = bmhq_pkg::ST_EMPTY;
               empty_refusals++;
            end else begin
               r.max_key = slot[1];
               moving = slot[fill_level];
               fill_level--;
               hole = 1;
               kid = 2;
               settled = 0;
               // sink toward the larger child, left one on a tie
               while (!settled && kid <= fill_level) begin
                  if (kid < fill_level && slot[kid + 1] > slot[kid])
                     kid++;
                  if (moving >= slot[kid]) begin
                     settled = 1;
                  end else begin
                     slot[hole] = slot[kid];
                     hole = kid;
                     kid = kid * 2;
                  end
               end
               slot[hole] = moving;
            end
         end
         if (fill_level > peak_fill)
            peak_fill = fill_level;
         r.entry_count = COUNT_W'(fill_level);
         pending.push_back(r);
      endfunction

      function void check_result(logic signed [31:0] got_key, logic [1:0] got_status,
                                 logic [7:0] got_count);
         queue_result_type want;
         if (pending.size() == 0) begin
            $error("result with nothing outstanding: max_key %0d status %0d entry_count %0d",
                   got_key, got_status, got_count);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         compared++;
         if (got_key !== want.max_key) begin
            $error("max_key: expected %0d, got %0d", want.max_key, got_key);
            mismatches++;
         end
         if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            mismatches++;
         end
         if (got_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got_count);
            mismatches++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_type;
   logic signed [31:0]          req_new_key;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [MAX_KEY_W-1:0] rsp_max_key;
   logic [1:0]                  rsp_status;
   logic [COUNT_W-1:0]          rsp_entry_count;

   heap_queue_scoreboard sb;
   int  cycle_count;
   int  sender_items;
   bit  sender_calm;

   binary_max_heap_queue_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_new_key     (req_new_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_max_key     (rsp_max_key),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   always #2 clock = ~clock;

   // mostly short pauses, now and then a long one
   function automatic int idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // random keys, with a share of small values for ties and of values near the extremes
   function automatic logic signed [31:0] next_key();
      int small_val;
      small_val = $urandom_range(0, 8);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom;
         5, 6, 7:       return small_val - 4;
         8:             return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
                                                    : 32'sh80000000 + $urandom_range(0, 3);
      endcase
   endfunction

   // offers one item and returns at the edge where it is taken; valid is left high
   task automatic send_item(input logic kind, input logic signed [31:0] key);
      int gap;
      if (sender_items % 40 == 0)
         sender_calm = ($urandom_range(0, 3) == 0);
      sender_items++;
      gap = sender_calm ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_new_key <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, key);
   endtask

   // result side: random back-pressure plus one long hold-off while the sender keeps going
   initial begin
      int  stall_left;
      int  rx_cycles;
      bit  held;
      bit  calm;
      stall_left = 0;
      rx_cycles = 0;
      held = 0;
      calm = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_max_key, rsp_status, rsp_entry_count);
         if (rx_cycles % 128 == 0)
            calm = ($urandom_range(0, 3) == 0);
         rx_cycles++;
         if (!held && sb.compared >= 30) begin
            held = 1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = calm ? 0 : idle_length();
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int bias;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_type    = bmhq_pkg::REQ_INSERT;
      req_new_key = '0;
      sender_items = 0;
      sender_calm  = 0;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty queue, extremes, ties
      send_item(bmhq_pkg::REQ_REMOVE, 32'sh12345678);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd0);
      send_item(bmhq_pkg::REQ_INSERT, 32'sh7FFFFFFF);
      send_item(bmhq_pkg::REQ_INSERT, 32'sh80000000);
      send_item(bmhq_pkg::REQ_INSERT, -32'sd1);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd5);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd5);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd5);
      repeat (7) send_item(bmhq_pkg::REQ_REMOVE, 32'shFFFFFFFF);
      send_item(bmhq_pkg::REQ_REMOVE, 32'sd0);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd1);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd1);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd1);
      send_item(bmhq_pkg::REQ_INSERT, 32'sd2);
      repeat (4) send_item(bmhq_pkg::REQ_REMOVE, 32'sd0);

      // fill to capacity and push past it, then drain past empty
      while (sb.fill_level < CAPACITY)
         send_item(($urandom_range(0, 9) == 0) ? bmhq_pkg::REQ_REMOVE : bmhq_pkg::REQ_INSERT,
                   next_key());
      repeat (6) send_item(bmhq_pkg::REQ_INSERT, next_key());
      while (sb.fill_level > 0)
         send_item(($urandom_range(0, 9) == 0) ? bmhq_pkg::REQ_INSERT : bmhq_pkg::REQ_REMOVE,
                   next_key());
      repeat (4) send_item(bmhq_pkg::REQ_REMOVE, next_key());

      // mixed traffic with a drifting insert/remove balance
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(0, 2))
            0:       bias = 25;
            1:       bias = 50;
            default: bias = 75;
         endcase
         repeat (50)
            send_item(($urandom_range(0, 99) < bias) ? bmhq_pkg::REQ_INSERT
                                                     : bmhq_pkg::REQ_REMOVE, next_key());
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Run covered %0d inserts (%0d refused as full)", sb.inserts, sb.full_refusals);
      $display("and %0d removes (%0d refused as empty); peak occupancy %0d",
               sb.removes, sb.empty_refusals, sb.peak_fill);
      $display("%0d results compared, %0d field mismatches", sb.compared, sb.mismatches);
      if (sb.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/bmhq_ctrl.sv
rtl/binary_max_heap_queue_unit.sv
bench/binary_max_heap_queue_unit_tb.sv
